// ----- rtl/taa_pkg.sv -----
// shared types and constants for the trie address allocator
// no dependencies; used by taa_row_find, trie_address_allocator_top, taa_lease_checker and the testbench
package taa_pkg;

	// default host field width of the subnet
	localparam int HOST_BITS_DEF = 8;

	// host bitmap is kept in rows of this many hosts
	localparam int ROW_W  = 16;
	localparam int ROW_BW = 4;

	// reserved hosts
	localparam int NETWORK_HOST   = 0;
	localparam int SERVER_HOST    = 254;
	localparam int BROADCAST_HOST = 255;
	localparam int RESERVED_COUNT = 3;

	// reset pattern of the bitmap rows that hold reserved hosts
	localparam int RSV_LO_ROW = NETWORK_HOST / ROW_W;
	localparam int RSV_HI_ROW = SERVER_HOST / ROW_W;
	localparam logic [ROW_W-1:0] RSV_LO_PAT = ROW_W'(1) << (NETWORK_HOST % ROW_W);
	localparam logic [ROW_W-1:0] RSV_HI_PAT =
		(ROW_W'(1) << (SERVER_HOST % ROW_W)) | (ROW_W'(1) << (BROADCAST_HOST % ROW_W));

	// result field widths
	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 9;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// result status codes
	typedef enum logic [2:0] {
		ST_SUGGESTED = 3'd0,
		ST_OTHER     = 3'd1,
		ST_FULL      = 3'd2,
		ST_FREED     = 3'd3,
		ST_IGNORED   = 3'd4
	} alloc_status_t;

	// outcome of a search within one bitmap row
	typedef struct packed {
		logic              found;
		logic [ROW_BW-1:0] idx;
	} find_t;

endpackage

// ----- rtl/taa_ram.sv -----
// generic single write port ram with one registered read port
// no dependencies
module taa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/taa_row_find.sv -----
// finds the lowest free host in one bitmap row, optionally at or above a start bit
// depends on taa_pkg
module taa_row_find (
	input  logic [taa_pkg::ROW_W-1:0]  row,
	input  logic [taa_pkg::ROW_BW-1:0] start_bit,
	input  logic                       use_start,
	output taa_pkg::find_t             res
);

	logic [taa_pkg::ROW_W-1:0] below;
	logic [taa_pkg::ROW_W-1:0] masked;

	// hosts below the start bit count as taken on the first row
	always_comb begin
		below  = use_start ? ((taa_pkg::ROW_W'(1) << start_bit) - taa_pkg::ROW_W'(1)) : '0;
		masked = row | below;
	end

	// priority pick of the lowest clear bit
	always_comb begin
		res = '0;
		for (int i = taa_pkg::ROW_W - 1; i >= 0; i--) begin
			if (!masked[i]) begin
				res.found = 1'b1;
				res.idx   = taa_pkg::ROW_BW'(i);
			end
		end
	end

endmodule

// ----- rtl/trie_address_allocator_top.sv -----
// top level of the trie address allocator: sequencer, bitmap ram and row search
// depends on taa_pkg, taa_ram, taa_row_find

// Host addresses of one subnet of 2^HOST_BITS hosts are handed out and taken back.
// The used bitmap sits in a ram of 16-host rows; one row search unit is reused on
// each row read. A transaction is taken when start is high and busy is low. Pool
// full is answered in the cycle after start; a free passes through the read and
// evaluate states to the result strobe; an allocate passes through read and evaluate
// for every row it visits, set by the one ram read per row. After reset busy stays
// high for a clearing pass that writes each of the 2^HOST_BITS/16 rows. Each result is shown
// for one cycle with done high and cannot be stalled by the receiver.
// Configuration writes of the subnet prefix are taken on any cycle.
module trie_address_allocator_top #(
	parameter int HOST_BITS = taa_pkg::HOST_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [taa_pkg::ADDR_W-1:0]    cfg_wdata,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [taa_pkg::ADDR_W-1:0]    request_address,
	output logic                          done,
	output logic [2:0]                    status,
	output logic [taa_pkg::ADDR_W-1:0]    granted_address,
	output logic [taa_pkg::COUNT_W-1:0]   free_count
);

	localparam int HOST_COUNT = 1 << HOST_BITS;
	localparam int ROWS       = HOST_COUNT / taa_pkg::ROW_W;
	localparam int ROW_AW     = HOST_BITS - taa_pkg::ROW_BW;
	localparam int FREE_W     = HOST_BITS + 1;
	localparam logic [FREE_W-1:0] FREE_INIT = FREE_W'(HOST_COUNT - taa_pkg::RESERVED_COUNT);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL
	} state_t;

	state_t                      state_q;
	logic [ROW_AW-1:0]           clr_q;
	logic [ROW_AW-1:0]           row_q;
	logic [taa_pkg::ROW_BW-1:0]  start_bit_q;
	logic [HOST_BITS-1:0]        start_host_q;
	logic                        first_q;
	logic                        op_q;
	logic                        other_q;
	logic [FREE_W-1:0]           free_q;
	logic [taa_pkg::ADDR_W-1:0]  subnet_q;
	logic                        done_q;
	taa_pkg::alloc_status_t      status_q;
	logic [taa_pkg::ADDR_W-1:0]  granted_q;
	logic [taa_pkg::COUNT_W-1:0] count_q;

	logic [taa_pkg::ROW_W-1:0]   rd_row;
	logic                        ram_we;
	logic [ROW_AW-1:0]           ram_waddr;
	logic [taa_pkg::ROW_W-1:0]   ram_wdata;
	taa_pkg::find_t              find;
	logic [taa_pkg::ROW_W-1:0]   bit_sel;
	logic                        host_set;
	logic [HOST_BITS-1:0]        found_host;
	logic [HOST_BITS-1:0]        req_host;
	logic [FREE_W-1:0]           free_dec;
	logic [FREE_W-1:0]           free_inc;

	// bitmap storage
	taa_ram #(
		.WIDTH(taa_pkg::ROW_W),
		.DEPTH(ROWS)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(row_q),
		.rdata(rd_row)
	);

	// shared row search
	taa_row_find u_find (
		.row      (rd_row),
		.start_bit(start_bit_q),
		.use_start(first_q),
		.res      (find)
	);

	// helpers for the evaluation step
	always_comb begin
		bit_sel    = op_q == taa_pkg::OP_FREE ? (taa_pkg::ROW_W'(1) << start_bit_q)
		                                      : (taa_pkg::ROW_W'(1) << find.idx);
		host_set   = rd_row[start_bit_q];
		found_host = {row_q, find.idx};
		req_host   = request_address == '0 ? HOST_BITS'(1)
		                                   : request_address[HOST_BITS-1:0];
		free_dec   = free_q - FREE_W'(1);
		free_inc   = free_q + FREE_W'(1);
	end

	// ram write: clearing pass, host take or host release
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = row_q;
		ram_wdata = rd_row | bit_sel;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			if (clr_q == ROW_AW'(taa_pkg::RSV_LO_ROW)) begin
				ram_wdata = taa_pkg::RSV_LO_PAT;
			end else if (clr_q == ROW_AW'(taa_pkg::RSV_HI_ROW)) begin
				ram_wdata = taa_pkg::RSV_HI_PAT;
			end else begin
				ram_wdata = '0;
			end
		end else if (state_q == S_EVAL) begin
			if (op_q == taa_pkg::OP_FREE) begin
				ram_we    = host_set;
				ram_wdata = rd_row & ~bit_sel;
			end else begin
				ram_we = find.found;
			end
		end
	end

	// saturate the free count into the result field
	function automatic logic [taa_pkg::COUNT_W-1:0] sat_count(input logic [FREE_W-1:0] n);
		if (n > FREE_W'(taa_pkg::COUNT_MAX)) begin
			return taa_pkg::COUNT_MAX;
		end
		return n[taa_pkg::COUNT_W-1:0];
	endfunction

	// sequencer, counters and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			row_q        <= '0;
			start_bit_q  <= '0;
			start_host_q <= '0;
			first_q      <= 1'b0;
			op_q         <= taa_pkg::OP_ALLOC;
			other_q      <= 1'b0;
			free_q       <= FREE_INIT;
			subnet_q     <= '0;
			done_q       <= 1'b0;
			status_q     <= taa_pkg::ST_SUGGESTED;
			granted_q    <= '0;
			count_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				subnet_q <= cfg_wdata;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ROW_AW'(1);
					if (clr_q == ROW_AW'(ROWS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q <= operation;
						if (operation == taa_pkg::OP_FREE) begin
							row_q       <= request_address[HOST_BITS-1:taa_pkg::ROW_BW];
							start_bit_q <= request_address[taa_pkg::ROW_BW-1:0];
							state_q     <= S_READ;
						end else if (free_q == '0) begin
							done_q    <= 1'b1;
							status_q  <= taa_pkg::ST_FULL;
							granted_q <= '0;
							count_q   <= sat_count(free_q);
						end else begin
							row_q        <= req_host[HOST_BITS-1:taa_pkg::ROW_BW];
							start_bit_q  <= req_host[taa_pkg::ROW_BW-1:0];
							start_host_q <= req_host;
							first_q      <= 1'b1;
							other_q      <= request_address == '0;
							state_q      <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (op_q == taa_pkg::OP_FREE) begin
						done_q    <= 1'b1;
						granted_q <= '0;
						state_q   <= S_IDLE;
						if (host_set) begin
							free_q   <= free_inc;
							status_q <= taa_pkg::ST_FREED;
							count_q  <= sat_count(free_inc);
						end else begin
							status_q <= taa_pkg::ST_IGNORED;
							count_q  <= sat_count(free_q);
						end
					end else if (find.found) begin
						done_q    <= 1'b1;
						free_q    <= free_dec;
						count_q   <= sat_count(free_dec);
						granted_q <= {subnet_q[taa_pkg::ADDR_W-1:HOST_BITS], found_host};
						status_q  <= (other_q || found_host != start_host_q)
						             ? taa_pkg::ST_OTHER : taa_pkg::ST_SUGGESTED;
						first_q   <= 1'b0;
						state_q   <= S_IDLE;
					end else begin
						// row full, move on to the next row with wrap
						row_q   <= row_q + ROW_AW'(1);
						first_q <= 1'b0;
						state_q <= S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy            = state_q != S_IDLE;
	assign done            = done_q;
	assign status          = status_q;
	assign granted_address = granted_q;
	assign free_count      = count_q;

endmodule

// ----- sim/taa_lease_checker.sv -----
`timescale 1ns / 100ps
// lease checker for the trie address allocator: keeps its own host pool,
// predicts each result and compares it with the result strobe; depends on taa_pkg
module taa_lease_checker #(
	parameter int HOST_BITS = taa_pkg::HOST_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [taa_pkg::ADDR_W-1:0]    cfg_wdata,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          operation,
	input  logic [taa_pkg::ADDR_W-1:0]    request_address,
	input  logic                          done,
	input  logic [2:0]                    status,
	input  logic [taa_pkg::ADDR_W-1:0]    granted_address,
	input  logic [taa_pkg::COUNT_W-1:0]   free_count,
	output int                            mismatches,
	output int                            in_flight
);
	import taa_pkg::*;

	localparam int HOST_COUNT = 1 << HOST_BITS;
	localparam logic [ADDR_W-1:0] HOST_MASK = ADDR_W'(HOST_COUNT - 1);

	typedef struct packed {
		alloc_status_t        st;
		logic [ADDR_W-1:0]    addr;
		logic [COUNT_W-1:0]   count;
	} lease_t;

	logic [ADDR_W-1:0] subnet_prefix;
	bit                host_taken [HOST_COUNT];
	int unsigned       free_hosts;
	int                error_count;
	lease_t            lease_q [$];

	// pool update for one transaction, returns the result it must produce
	task automatic grant_or_release(input logic op, input logic [ADDR_W-1:0] req,
			output lease_t res);
		logic [ADDR_W-1:0] host;
		bit moved;
		res.addr = '0;
		if (op == OP_ALLOC) begin
			if (free_hosts == 0) begin
				res.st = ST_FULL;
			end else begin
				// zero means no suggestion: search from host 1
				moved = (req == '0);
				host = moved ? (ADDR_W'(1) & HOST_MASK) : (req & HOST_MASK);
				while (host_taken[host]) begin
					host = (host + 1) & HOST_MASK;
					moved = 1'b1;
				end
				host_taken[host] = 1'b1;
				free_hosts--;
				res.st = moved ? ST_OTHER : ST_SUGGESTED;
				res.addr = (subnet_prefix & ~HOST_MASK) | host;
			end
		end else begin
			host = req & HOST_MASK;
			if (host_taken[host]) begin
				host_taken[host] = 1'b0;
				free_hosts++;
				res.st = ST_FREED;
			end else begin
				res.st = ST_IGNORED;
			end
		end
		res.count = (free_hosts > COUNT_MAX) ? COUNT_MAX : COUNT_W'(free_hosts);
	endtask

	// retire results against the oldest expectation, then admit new transactions
	always @(posedge clk or negedge arst_n) begin
		lease_t want;
		if (!arst_n) begin
			subnet_prefix = '0;
			foreach (host_taken[h])
				host_taken[h] = 1'b0;
			host_taken[NETWORK_HOST] = 1'b1;
			host_taken[SERVER_HOST] = 1'b1;
			host_taken[BROADCAST_HOST] = 1'b1;
			free_hosts = HOST_COUNT - RESERVED_COUNT;
			lease_q.delete();
			error_count = 0;
		end else begin
			if (done) begin
				if (lease_q.size() == 0) begin
					$error("result strobe with no transaction outstanding");
					error_count++;
				end else begin
					want = lease_q.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, actual %0d", want.st, status);
						error_count++;
					end
					if (granted_address !== want.addr) begin
						$error("granted_address: expected %h, actual %h",
							want.addr, granted_address);
						error_count++;
					end
					if (free_count !== want.count) begin
						$error("free_count: expected %0d, actual %0d", want.count, free_count);
						error_count++;
					end
				end
			end
			if (start && !busy) begin
				grant_or_release(operation, request_address, want);
				lease_q.push_back(want);
			end
			if (cfg_we)
				subnet_prefix = cfg_wdata;
		end
		mismatches <= error_count;
		in_flight <= lease_q.size();
	end

endmodule

// ----- sim/tb_trie_address_allocator_top.sv -----
`timescale 1ns / 100ps
// testbench top for the trie address allocator: clock, reset, stimulus and verdict
// depends on taa_pkg, trie_address_allocator_top and taa_lease_checker
module tb_trie_address_allocator_top;
	import taa_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 148;
	localparam int SETTLE      = 40;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [ADDR_W-1:0]     cfg_wdata = '0;
	logic                  start = 1'b0;
	logic                  operation = OP_ALLOC;
	logic [ADDR_W-1:0]     request_address = '0;
	logic                  busy;
	logic                  done;
	logic [2:0]            status;
	logic [ADDR_W-1:0]     granted_address;
	logic [COUNT_W-1:0]    free_count;
	int                    mismatches;
	int                    in_flight;
	int                    idle_cycles = 0;
	int                    burst_left = 1;

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	trie_address_allocator_top i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.request_address (request_address),
		.done            (done),
		.status          (status),
		.granted_address (granted_address),
		.free_count      (free_count)
	);

	taa_lease_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.request_address (request_address),
		.done            (done),
		.status          (status),
		.granted_address (granted_address),
		.free_count      (free_count),
		.mismatches      (mismatches),
		.in_flight       (in_flight)
	);

	// watchdog on cycles where nothing is transferred
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// subnet prefix write, only while no transaction is outstanding
	task automatic write_prefix(input logic [ADDR_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one transaction, then burst pacing with random gaps
	task automatic issue(input logic op, input logic [ADDR_W-1:0] addr);
		int gap;
		start <= 1'b1;
		operation <= op;
		request_address <= addr;
		do
			@(posedge clk);
		while (busy);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold off until every outstanding result has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
	endtask

	// random request: mostly full-width, some no-suggestion, some near the top
	function automatic logic [ADDR_W-1:0] pick_address();
		logic [ADDR_W-1:0] addr;
		addr = $urandom();
		case ($urandom_range(0, 9))
			0: addr = '0;
			1: addr[7:0] = 8'(250 + $urandom_range(0, 5));
			default: ;
		endcase
		return addr;
	endfunction

	initial begin
		int alloc_pct [PHASES] = '{60, 100, 90, 15, 100, 40, 5, 85, 50};
		logic [ADDR_W-1:0] prefix;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: prefix with host bits set, no suggestion, wrap, reserved hosts
		write_prefix(32'hC0A8_01FF);
		issue(OP_ALLOC, 32'h0000_0000);
		issue(OP_ALLOC, 32'h0000_0000);
		issue(OP_ALLOC, 32'h0000_0005);
		issue(OP_ALLOC, 32'hFFFF_FF05);
		issue(OP_ALLOC, 32'h0000_00FE);
		issue(OP_ALLOC, 32'h8000_0080);
		issue(OP_FREE,  32'h0000_0005);
		issue(OP_FREE,  32'h0000_0005);
		issue(OP_FREE,  32'h0000_0000);
		issue(OP_FREE,  32'h7654_32FE);
		issue(OP_FREE,  32'hFFFF_FFFF);
		issue(OP_ALLOC, 32'h0000_01FF);
		issue(OP_ALLOC, 32'h0000_0100);
		issue(OP_FREE,  32'h0000_0000);
		issue(OP_ALLOC, 32'hFFFF_FFFF);
		issue(OP_FREE,  32'h0000_0080);
		issue(OP_ALLOC, 32'h7FFF_FF7F);
		drain();

		// random phases, each with its own prefix and allocate/free mix
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: prefix = 32'hFFFF_FFFF;
				1: prefix = 32'h0000_0000;
				default: prefix = $urandom();
			endcase
			write_prefix(prefix);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(1, 100) <= alloc_pct[p])
					issue(OP_ALLOC, pick_address());
				else
					issue(OP_FREE, pick_address());
			end
			drain();
		end

		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
